>>> rtl/core/txbb_pkg.sv
`timescale 1ns / 1ps

package txbb_pkg;

  // Bucket table depth and reset value of the width limit
  localparam int unsigned BucketsDefault    = 512;
  localparam logic [15:0] MaxFaceWidthReset = 16'h01f4;

  // Register index codes, taken from paddr[2]
  localparam logic RegMaxFaceWidth = 1'b0;

  // Input item (tdata), lowest field last in this declaration
  typedef struct packed {
    logic [15:0]        context_id;
    logic [15:0]        clip_c;
    logic [15:0]        clip_b;
    logic [15:0]        clip_a;
    logic signed [15:0] x_c;
    logic signed [15:0] x_b;
    logic signed [15:0] x_a;
    logic [15:0]        vert_c;
    logic [15:0]        vert_b;
    logic [15:0]        vert_a;
    logic [15:0]        face_addr;
  } face_in_t;

  // Per-face decision from the classifier
  typedef struct packed {
    logic        visible;
    logic        insert;
    logic        overflow;
    logic        reordered;
    logic        behind;
    logic [15:0] first_vertex;
    logic [15:0] second_vertex;
    logic [15:0] third_vertex;
  } face_dec_t;

endpackage

>>> rtl/core/txbb_ram.sv
`timescale 1ns / 1ps

module txbb_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 512,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Read-first: a read and a write at one address return the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/txbb_face.sv
`timescale 1ns / 1ps

module txbb_face #(
  parameter int unsigned Buckets = txbb_pkg::BucketsDefault,
  parameter int unsigned IdxW    = $clog2(Buckets)
) (
  input  txbb_pkg::face_in_t  face_i,
  input  logic [15:0]         max_width_i,
  output txbb_pkg::face_dec_t dec_o,
  output logic [IdxW-1:0]     idx_o
);

  localparam logic signed [16:0] BucketsS = 17'(Buckets);

  logic               visible;
  logic [15:0]        clip_and;
  logic [15:0]        clip_or;
  logic signed [15:0] m0;
  logic signed [15:0] m1;
  logic signed [15:0] m2;
  logic [16:0]        span1;
  logic [16:0]        span2;
  logic               narrow;

  always_comb begin
    clip_and = face_i.clip_a & face_i.clip_b & face_i.clip_c;
    clip_or  = face_i.clip_a | face_i.clip_b | face_i.clip_c;
    visible  = (clip_and == 16'd0);

    dec_o.visible       = visible;
    dec_o.behind        = visible & clip_or[15];
    dec_o.reordered     = 1'b0;
    dec_o.first_vertex  = face_i.vert_a;
    dec_o.second_vertex = face_i.vert_b;
    dec_o.third_vertex  = face_i.vert_c;
    m0 = face_i.x_a;
    m1 = face_i.x_b;
    m2 = face_i.x_c;

    // Rotate so the smallest x leads, keeping winding
    if (visible) begin
      if (face_i.x_b > face_i.x_c) begin
        if (face_i.x_a >= face_i.x_c) begin
          dec_o.first_vertex  = face_i.vert_c;
          dec_o.second_vertex = face_i.vert_a;
          dec_o.third_vertex  = face_i.vert_b;
          m0 = face_i.x_c;
          m1 = face_i.x_a;
          m2 = face_i.x_b;
          dec_o.reordered = 1'b1;
        end
      end else if (face_i.x_a > face_i.x_b) begin
        dec_o.first_vertex  = face_i.vert_b;
        dec_o.second_vertex = face_i.vert_c;
        dec_o.third_vertex  = face_i.vert_a;
        m0 = face_i.x_b;
        m1 = face_i.x_c;
        m2 = face_i.x_a;
        dec_o.reordered = 1'b1;
      end
    end

    // For a visible face m0 is the minimum, so both spans are non-negative
    span1  = 17'({m1[15], m1} - {m0[15], m0});
    span2  = 17'({m2[15], m2} - {m0[15], m0});
    narrow = visible && (span1 < {1'b0, max_width_i}) && (span2 < {1'b0, max_width_i});

    dec_o.overflow = narrow && ($signed({m0[15], m0}) >= BucketsS);
    dec_o.insert   = narrow && !dec_o.overflow;
    idx_o          = m0[15] ? '0 : m0[IdxW-1:0];
  end

endmodule

>>> rtl/core/triangle_x_bucket_binner_core.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Payload
// s_axis    in         tvalid/tready         tdata faces, tlast end of context
// m_axis    out        tvalid/tready         tdata binning result per face
// apb       in         psel/penable/pwrite   max_face_width at byte address 0
//
// One face per cycle sustained while m_axis_tready is high; the result passes
// through the input register, then the result register.
// The bucket head read and the new head write share one cycle on the RAM, so
// back-to-back faces on one bucket chain correctly without a bubble.
// After reset a clearing pass zeroes the bucket table, one entry a cycle;
// s_axis_tready stays low until it ends.
// A stalled result holds in the output register while one more face waits
// in the input register.

module triangle_x_bucket_binner_core #(
  parameter int unsigned Buckets = txbb_pkg::BucketsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // face_addr, vert_a, vert_b, vert_c, x_a, x_b, x_c, clip_a, clip_b, clip_c,
  // context_id (16 bits each)
  input  logic [175:0] s_axis_tdata,
  input  logic         s_axis_tlast,  // end_of_context
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // visible, inserted, link_out[16], first_vertex[16], second_vertex[16],
  // third_vertex[16], reordered, bucket_overflow, behind_report,
  // report_context[16], 3 zero bits
  output logic [87:0]  m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned IdxW    = $clog2(Buckets);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Buckets - 1);

  logic                clearing_q;
  logic [IdxW-1:0]     clr_idx_q;
  logic [15:0]         max_width_q;
  logic                s1_valid_q;
  txbb_pkg::face_in_t  s1_face_q;
  logic                s1_eoc_q;
  logic                s2_valid_q;
  txbb_pkg::face_dec_t s2_dec_q;
  logic                s2_report_q;
  logic [15:0]         s2_rctx_q;
  logic                behind_pending_q;
  logic                behind_pending_d;

  txbb_pkg::face_dec_t dec;
  logic [IdxW-1:0]     idx;
  logic                s2_free;
  logic                s1_move;
  logic                report;
  logic                ram_we;
  logic [IdxW-1:0]     ram_waddr;
  logic [15:0]         ram_wdata;
  logic [15:0]         ram_rdata;
  logic [15:0]         link;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == txbb_pkg::RegMaxFaceWidth) ? {16'd0, max_width_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_width_q <= txbb_pkg::MaxFaceWidthReset;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == txbb_pkg::RegMaxFaceWidth) begin
      max_width_q <= pwdata[15:0];
    end
  end

  // Pipeline control
  assign s2_free       = !s2_valid_q || m_axis_tready;
  assign s1_move       = s1_valid_q && s2_free;
  assign s_axis_tready = !clearing_q && (!s1_valid_q || s2_free);

  txbb_face #(
    .Buckets(Buckets),
    .IdxW   (IdxW)
  ) u_face (
    .face_i     (s1_face_q),
    .max_width_i(max_width_q),
    .dec_o      (dec),
    .idx_o      (idx)
  );

  // The closing face's own behind flag counts for its context
  assign report           = s1_eoc_q && (behind_pending_q || dec.behind);
  assign behind_pending_d = s1_eoc_q ? 1'b0 : (behind_pending_q || dec.behind);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q       <= 1'b1;
      clr_idx_q        <= '0;
      s1_valid_q       <= 1'b0;
      s2_valid_q       <= 1'b0;
      behind_pending_q <= 1'b0;
    end else begin
      if (clearing_q) begin
        clr_idx_q <= clr_idx_q + IdxW'(1);
        if (clr_idx_q == LastIdx) begin
          clearing_q <= 1'b0;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        s2_valid_q       <= 1'b1;
        behind_pending_q <= behind_pending_d;
      end else if (m_axis_tready) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_face_q <= s_axis_tdata;
      s1_eoc_q  <= s_axis_tlast;
    end
    if (s1_move) begin
      s2_dec_q    <= dec;
      s2_report_q <= report;
      s2_rctx_q   <= report ? s1_face_q.context_id : 16'd0;
    end
  end

  // Bucket table: clearing pass owns the write port until it ends
  assign ram_we    = clearing_q || (s1_move && dec.insert);
  assign ram_waddr = clearing_q ? clr_idx_q : idx;
  assign ram_wdata = clearing_q ? 16'd0 : s1_face_q.face_addr;

  txbb_ram #(
    .Width(16),
    .Depth(Buckets),
    .AddrW(IdxW)
  ) u_heads (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (s1_move && dec.insert),
    .raddr_i(idx),
    .rdata_o(ram_rdata)
  );

  assign link = s2_dec_q.insert ? ram_rdata : 16'd0;

  assign m_axis_tvalid = s2_valid_q;
  assign m_axis_tdata  = {3'd0, s2_rctx_q, s2_report_q, s2_dec_q.overflow,
                          s2_dec_q.reordered, s2_dec_q.third_vertex,
                          s2_dec_q.second_vertex, s2_dec_q.first_vertex,
                          link, s2_dec_q.insert, s2_dec_q.visible};

`ifndef SYNTH
  a_no_accept_while_clearing : assert property (
    @(posedge clk_i) disable iff (!rst_ni) clearing_q |-> !s_axis_tready
  ) else $error("item accepted during bucket clearing");

  a_insert_excludes_overflow : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      s2_valid_q && s2_dec_q.insert |-> s2_dec_q.visible && !s2_dec_q.overflow
  ) else $error("inserted face not visible or overflowed");

  a_eoc_clears_pending : assert property (
    @(posedge clk_i) disable iff (!rst_ni) s1_move && s1_eoc_q |=> !behind_pending_q
  ) else $error("behind flag survived end of context");

  a_stalled_result_holds : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid && !m_axis_tready |=> $stable(link) && $stable(s2_dec_q)
  ) else $error("stalled result changed");
`endif

endmodule
